### src/cema_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded EMA hysteresis detector package
// Shared constants for the filter bank, the comparator and the register port.
// ----------------------------------------------------------------------------
package cema_pkg;

   localparam int STAGES_DEF      = 4;
   localparam int SHIFT_DEF       = 4;
   localparam int SAMPLE_BITS_DEF = 12;

   localparam int THR_W     = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [THR_W-1:0] UPPER_RESET = 12'd2056;
   localparam logic [THR_W-1:0] LOWER_RESET = 12'd2040;

   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_IDX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_IDX = 2'd1;

endpackage

### src/cema_chain.sv
// ----------------------------------------------------------------------------
// Filter chain and comparator
// Updates one channel's leaky integrators in cascade and applies hysteresis
// to the last stage output.
// ----------------------------------------------------------------------------
module cema_chain
   import cema_pkg::*;
#(
   parameter int STAGES      = STAGES_DEF,
   parameter int SHIFT       = SHIFT_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic [STAGES-1:0][SAMPLE_BITS+SHIFT-1:0] acc_cur,
   input  logic                                     level_cur,
   input  logic [SAMPLE_BITS-1:0]                   sample,
   input  logic [THR_W-1:0]                         upper,
   input  logic [THR_W-1:0]                         lower,
   output logic [STAGES-1:0][SAMPLE_BITS+SHIFT-1:0] acc_next,
   output logic                                     level_next,
   output logic [SAMPLE_BITS-1:0]                   filtered
);

   localparam int ACC_W = SAMPLE_BITS + SHIFT;
   localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

   logic [STAGES:0][SAMPLE_BITS-1:0] tap;
   logic                             above;
   logic                             below;

   assign tap[0] = sample;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      assign acc_next[k] = acc_cur[k] - ACC_W'(acc_cur[k][ACC_W-1:SHIFT])
                         + ACC_W'(tap[k]);
      assign tap[k+1]    = acc_next[k][ACC_W-1:SHIFT];
   end

   assign filtered = tap[STAGES];
   assign above    = CMP_W'(filtered) > CMP_W'(upper);
   assign below    = CMP_W'(filtered) < CMP_W'(lower);

   always_comb begin
      if (above) begin
         level_next = 1'b1;
      end else if (below) begin
         level_next = 1'b0;
      end else begin
         level_next = level_cur;
      end
   end

endmodule

### src/cascaded_ema_hysteresis_detector_top.sv
// ----------------------------------------------------------------------------
// Cascaded EMA hysteresis detector
// Two channel banks of cascaded leaky integrators held in a state memory,
// with a hysteresis comparator on the last stage of each bank.
// ----------------------------------------------------------------------------
// A taken sample is held in stage 1, then its result in the output register.
// Throughput: one sample per cycle unless results stall; the state memory is
// read on acceptance, written as stage 1 advances, and forwarded to next read.
// Reset: the thresholds return to their defaults and per-entry valid flags make
// both banks read as zero at once, so no clearing pass is needed.
module cascaded_ema_hysteresis_detector_top
   import cema_pkg::*;
#(
   parameter int STAGES      = STAGES_DEF,
   parameter int SHIFT       = SHIFT_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_channel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_level,
   output logic [SAMPLE_BITS-1:0] rsp_filtered,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [THR_W-1:0]       csr_wdata
);

   localparam int ACC_W = SAMPLE_BITS + SHIFT;
   localparam int ENT_W = STAGES * ACC_W + 1;

   typedef logic [STAGES-1:0][ACC_W-1:0] acc_vec_type;

   logic [ENT_W-1:0]       mem [2];
   logic [ENT_W-1:0]       rd_data_ff;
   logic [1:0]             ent_valid_ff, ent_valid_in;
   logic                   wb_valid_ff, wb_valid_in;
   logic                   wb_ch_ff;
   logic [ENT_W-1:0]       wb_data_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_ch_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_level_ff;
   logic [SAMPLE_BITS-1:0] out_filtered_ff;
   logic [THR_W-1:0]       upper_ff, upper_in;
   logic [THR_W-1:0]       lower_ff, lower_in;

   logic                   req_accept;
   logic                   s1_adv;
   logic [ENT_W-1:0]       cur_entry;
   logic [ENT_W-1:0]       new_entry;
   acc_vec_type            acc_cur;
   acc_vec_type            acc_next;
   logic                   level_next;
   logic [SAMPLE_BITS-1:0] filtered;

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (wb_valid_ff && (wb_ch_ff == s1_ch_ff)) begin
         cur_entry = wb_data_ff;
      end else if (ent_valid_ff[s1_ch_ff]) begin
         cur_entry = rd_data_ff;
      end else begin
         cur_entry = '0;
      end
   end

   assign acc_cur   = cur_entry[ENT_W-1:1];
   assign new_entry = {acc_next, level_next};

   cema_chain #(
      .STAGES      (STAGES),
      .SHIFT       (SHIFT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_chain (
      .acc_cur    (acc_cur),
      .level_cur  (cur_entry[0]),
      .sample     (s1_sample_ff),
      .upper      (upper_ff),
      .lower      (lower_ff),
      .acc_next   (acc_next),
      .level_next (level_next),
      .filtered   (filtered)
   );

   always_comb begin
      s1_valid_in  = s1_adv ? 1'b0 : s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end
      ent_valid_in = ent_valid_ff;
      wb_valid_in  = wb_valid_ff;
      if (s1_adv) begin
         ent_valid_in[s1_ch_ff] = 1'b1;
         wb_valid_in            = 1'b1;
      end
      upper_in = upper_ff;
      lower_in = lower_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_UPPER_IDX: upper_in = csr_wdata;
            CSR_LOWER_IDX: lower_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ent_valid_ff <= '0;
         wb_valid_ff  <= 1'b0;
         upper_ff     <= UPPER_RESET;
         lower_ff     <= LOWER_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         ent_valid_ff <= ent_valid_in;
         wb_valid_ff  <= wb_valid_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff   <= mem[req_channel];
         s1_ch_ff     <= req_channel;
         s1_sample_ff <= req_sample;
      end
      if (s1_adv) begin
         mem[s1_ch_ff]   <= new_entry;
         wb_ch_ff        <= s1_ch_ff;
         wb_data_ff      <= new_entry;
         out_level_ff    <= level_next;
         out_filtered_ff <= filtered;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_level    = out_level_ff;
   assign rsp_filtered = out_filtered_ff;

   a_adv_loads_output: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid)
      else $error("result register not loaded after stage advance");

   a_write_marks_entry: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> ent_valid_ff[$past(s1_ch_ff)])
      else $error("written state entry not marked valid");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff))
      else $error("input stalled with a free pipeline");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the cascaded EMA hysteresis detector
// Streams converter samples into both filter banks under random source gaps
// and random result back-pressure. An independent model of the integrator
// cascade and the hysteresis comparator predicts every result beat, and each
// beat is checked in order. The threshold registers are rewritten between
// phases: at reset values, equal to the filtered value, crossed, at the
// extremes and at random, and the unused register indexes are also written.
// ----------------------------------------------------------------------------
module tb;
   import cema_pkg::*;

   localparam int SB = SAMPLE_BITS_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX_B = 2'd3;
   localparam logic [SB-1:0] FULL_SCALE = '1;
   localparam logic [SB-1:0] ZERO_SCALE = '0;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BEATS  = 200;

   typedef enum int {
      THR_WINDOW,
      THR_CROSSED,
      THR_EXTREME,
      THR_RANDOM
   } thr_mode_type;

   typedef struct packed {
      logic          level;
      logic [SB-1:0] filtered;
   } detection_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [SB-1:0]        req_sample;
   logic                 req_channel;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_level;
   logic [SB-1:0]        rsp_filtered;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [THR_W-1:0]     csr_wdata;

   logic [31:0]      bank_acc [2][STAGES_DEF];
   logic             bank_level [2];
   logic [THR_W-1:0] upper_thr;
   logic [THR_W-1:0] lower_thr;
   detection_type    detection_q[$];

   int errors;
   int samples_sent;
   int results_checked;
   int high_results;
   int csr_writes;
   int stall_left;
   bit req_gaps_on;
   bit rsp_stalls_on;

   cascaded_ema_hysteresis_detector_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .req_channel (req_channel),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_level   (rsp_level),
      .rsp_filtered(rsp_filtered),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Run timed out at %0t with %0d results outstanding.", $time,
               detection_q.size());
      $display("simulation failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // Runs one sample through the addressed bank; the state is only updated
   // when commit is set, so the next filtered value can be looked up first.
   function automatic detection_type advance_filter_bank(input logic ch,
                                                         input logic [SB-1:0] s,
                                                         input bit commit);
      logic [31:0]   acc;
      logic [31:0]   x;
      detection_type d;
      int            k;
      x = 32'(s);
      for (k = 0; k < STAGES_DEF; k++) begin
         acc = bank_acc[ch][k];
         acc = acc - (acc >> SHIFT_DEF) + x;
         x = acc >> SHIFT_DEF;
         if (commit) bank_acc[ch][k] = acc;
      end
      d.filtered = x[SB-1:0];
      d.level = bank_level[ch];
      if (d.filtered > upper_thr) begin
         d.level = 1'b1;
      end else if (d.filtered < lower_thr) begin
         d.level = 1'b0;
      end
      if (commit) bank_level[ch] = d.level;
      return d;
   endfunction

   function automatic logic [SB-1:0] next_filtered(input logic ch, input logic [SB-1:0] s);
      detection_type d;
      d = advance_filter_bank(ch, s, 1'b0);
      return d.filtered;
   endfunction

   // Leaves req_valid high after the beat so that back-to-back beats never
   // lower and raise it within one time step.
   task automatic send_sample(input logic [SB-1:0] s, input logic ch);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= s;
      req_channel <= ch;
      do @(posedge clock); while (req_stall);
      detection_q.push_back(advance_filter_bank(ch, s, 1'b1));
      samples_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (detection_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_UPPER_IDX) begin
         upper_thr = data;
      end else if (idx == CSR_LOWER_IDX) begin
         lower_thr = data;
      end
      csr_writes++;
   endtask

   task automatic set_thresholds(input logic [THR_W-1:0] up, input logic [THR_W-1:0] lo);
      drain();
      csr_write(CSR_UPPER_IDX, up);
      csr_write(CSR_LOWER_IDX, lo);
      csr_valid <= 1'b0;
   endtask

   // Reset thresholds, full-scale and zero samples on both banks.
   task automatic test_sample_extremes();
      repeat (8) send_sample(FULL_SCALE, 1'b0);
      send_sample(ZERO_SCALE, 1'b1);
      send_sample(FULL_SCALE, 1'b1);
      send_sample(FULL_SCALE, 1'b1);
      send_sample(ZERO_SCALE, 1'b1);
   endtask

   // A filtered value equal to a threshold must leave the level as it is.
   task automatic test_threshold_equality();
      set_thresholds(next_filtered(1'b0, FULL_SCALE), ZERO_SCALE);
      send_sample(FULL_SCALE, 1'b0);
      set_thresholds(ZERO_SCALE, ZERO_SCALE);
      send_sample(FULL_SCALE, 1'b0);
      set_thresholds(FULL_SCALE, next_filtered(1'b0, FULL_SCALE));
      send_sample(FULL_SCALE, 1'b0);
      set_thresholds(FULL_SCALE, FULL_SCALE);
      send_sample(FULL_SCALE, 1'b0);
   endtask

   // With the upper threshold below the lower one the upper test wins.
   task automatic test_crossed_thresholds();
      set_thresholds(ZERO_SCALE, FULL_SCALE);
      send_sample(FULL_SCALE, 1'b0);
      set_thresholds(next_filtered(1'b0, ZERO_SCALE), FULL_SCALE);
      send_sample(ZERO_SCALE, 1'b0);
   endtask

   // Writes to the unused indexes must not disturb either threshold.
   task automatic test_spare_registers();
      set_thresholds(UPPER_RESET, LOWER_RESET);
      csr_write(CSR_SPARE_IDX_A, THR_W'($urandom));
      csr_write(CSR_SPARE_IDX_B, THR_W'($urandom));
      csr_valid <= 1'b0;
      send_sample(FULL_SCALE, 1'b0);
      send_sample(ZERO_SCALE, 1'b1);
   endtask

   // Mostly sustained runs on one bank, so that the slow cascade swings right
   // across the thresholds, with bursts of unrelated samples in between.
   task automatic test_random_stream(input thr_mode_type mode);
      logic [THR_W-1:0] up;
      logic [THR_W-1:0] lo;
      int               target;
      int               run_len;
      int               base;
      int               spread;
      int               v;
      bit               steady;
      logic             ch;
      case (mode)
         THR_WINDOW: begin
            lo = THR_W'($urandom_range(1024, 3000));
            up = lo + THR_W'($urandom_range(0, 300));
         end
         THR_CROSSED: begin
            up = THR_W'($urandom_range(500, 2000));
            lo = up + THR_W'($urandom_range(1, 1500));
         end
         THR_EXTREME: begin
            up = $urandom_range(0, 1) ? FULL_SCALE : ZERO_SCALE;
            lo = $urandom_range(0, 1) ? FULL_SCALE : ZERO_SCALE;
         end
         default: begin
            up = THR_W'($urandom);
            lo = THR_W'($urandom);
         end
      endcase
      set_thresholds(up, lo);
      req_gaps_on   = ($urandom_range(0, 3) != 0);
      rsp_stalls_on = ($urandom_range(0, 3) != 0);
      target = samples_sent + PHASE_BEATS;
      while (samples_sent < target) begin
         ch      = 1'($urandom_range(0, 1));
         run_len = $urandom_range(10, 80);
         if (run_len > target - samples_sent) run_len = target - samples_sent;
         steady  = ($urandom_range(0, 9) < 7);
         case ($urandom_range(0, 2))
            0: base = 4095 - $urandom_range(0, 400);
            1: base = $urandom_range(0, 400);
            default: base = $urandom_range(0, 4095);
         endcase
         spread = $urandom_range(0, 300);
         repeat (run_len) begin
            if (steady) begin
               v = base + $urandom_range(0, 2 * spread) - spread;
               if (v < 0) v = 0;
               if (v > 4095) v = 4095;
               send_sample(SB'(v), ch);
            end else begin
               send_sample(SB'($urandom), 1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      detection_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (detection_q.size() == 0) begin
               errors++;
               $display("%0t: result beat with none expected: level %0b filtered %0d",
                        $time, rsp_level, rsp_filtered);
            end else begin
               want = detection_q.pop_front();
               results_checked++;
               if (rsp_level === 1'b1) high_results++;
               if (rsp_level !== want.level) begin
                  errors++;
                  $display("%0t: level mismatch: expected %0b, actual %0b",
                           $time, want.level, rsp_level);
               end
               if (rsp_filtered !== want.filtered) begin
                  errors++;
                  $display("%0t: filtered mismatch: expected %0d, actual %0d",
                           $time, want.filtered, rsp_filtered);
               end
            end
         end
         if (stall_left == 0 && rsp_stalls_on && $urandom_range(0, 99) < 20) begin
            stall_left = 1 + pick_gap();
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   initial begin
      int k;
      errors          = 0;
      samples_sent    = 0;
      results_checked = 0;
      high_results    = 0;
      csr_writes      = 0;
      stall_left      = 0;
      req_gaps_on     = 1'b1;
      rsp_stalls_on   = 1'b1;
      for (k = 0; k < STAGES_DEF; k++) begin
         bank_acc[0][k] = '0;
         bank_acc[1][k] = '0;
      end
      bank_level[0] = 1'b0;
      bank_level[1] = 1'b0;
      upper_thr     = UPPER_RESET;
      lower_thr     = LOWER_RESET;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_sample  <= '0;
      req_channel <= 1'b0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_UPPER_IDX;
      csr_wdata   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_sample_extremes();
      test_threshold_equality();
      test_crossed_thresholds();
      test_spare_registers();
      test_random_stream(THR_WINDOW);
      test_random_stream(THR_CROSSED);
      test_random_stream(THR_EXTREME);
      test_random_stream(THR_RANDOM);
      drain();

      $display("Sent %0d sample beats to both banks; %0d result beats checked, %0d high.",
               samples_sent, results_checked, high_results);
      $display("Made %0d register writes: reset, equal, crossed, extreme and random limits.",
               csr_writes);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
